[hw/rtl/longitudinal_jerk_limited_regulator_core_assert.svh]
// Assertion macros shared by the regulator RTL.
// Included by modules that check their own sequencing; no other dependencies.
`ifndef LONGITUDINAL_JERK_LIMITED_REGULATOR_CORE_ASSERT_SVH
`define LONGITUDINAL_JERK_LIMITED_REGULATOR_CORE_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, checked out of reset
`define LJR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("regulator assertion failed");
// Next-cycle implication, checked out of reset
`define LJR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("regulator assertion failed");
`else
`define LJR_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define LJR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[hw/rtl/ljr_pkg.sv]
// Types, constants and saturation helpers for the longitudinal regulator.
// No dependencies; imported by every regulator module.
package ljr_pkg;

    localparam int unsigned CFG_W   = 31;
    localparam int unsigned CFG_IDX_W = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LIMIT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_LIMIT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_JERK_STEP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_GAIN    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_POSITION_GAIN = 3'd5;

    // Reset values, Q16.16
    localparam logic [CFG_W-1:0] RST_SPEED_LIMIT   = 31'd1441792;
    localparam logic [CFG_W-1:0] RST_ACCEL_LIMIT   = 31'd655360;
    localparam logic [CFG_W-1:0] RST_JERK_STEP     = 31'd13107;
    localparam logic [CFG_W-1:0] RST_SAMPLE_PERIOD = 31'd1311;
    localparam logic [CFG_W-1:0] RST_SPEED_GAIN    = 31'd178737;
    localparam logic [CFG_W-1:0] RST_POSITION_GAIN = 31'd39715;

    localparam logic signed [48:0] S32_MAX = 49'sd2147483647;
    localparam logic signed [48:0] S32_MIN = -49'sd2147483648;
    localparam logic signed [48:0] S48_MAX = 49'sd140737488355327;
    localparam logic signed [48:0] S48_MIN = -49'sd140737488355328;

    typedef struct packed {
        logic [CFG_W-1:0] speed_limit;
        logic [CFG_W-1:0] accel_limit;
        logic [CFG_W-1:0] jerk_step;
        logic [CFG_W-1:0] sample_period;
        logic [CFG_W-1:0] speed_gain;
        logic [CFG_W-1:0] position_gain;
    } t_cfg;

    typedef enum logic [1:0] {
        MUL_POS_ERR,   // position error * position gain
        MUL_SPD_ERR,   // speed error * speed gain
        MUL_SPD_PER,   // model speed * sample period
        MUL_ACC_PER    // accel command * sample period
    } t_mul_sel;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_POS,
        ST_TERM,
        ST_VREF,
        ST_VERR,
        ST_MUL_SPD,
        ST_ACC,
        ST_DU,
        ST_U,
        ST_MUL_PSP,
        ST_POS,
        ST_MUL_UP,
        ST_SPD
    } t_state;

    typedef struct packed {
        logic     in_ready;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     ld_term;
        logic     ld_vref;
        logic     ld_verr;
        logic     ld_acc;
        logic     ld_du;
        logic     ld_u;
        logic     ld_pos;
        logic     ld_spd;
    } t_ctrl;

    function automatic logic signed [48:0] f_ext32(input logic signed [31:0] v);
        return {{17{v[31]}}, v};
    endfunction

    function automatic logic signed [48:0] f_ext48(input logic signed [47:0] v);
        return {v[47], v};
    endfunction

    function automatic logic signed [31:0] f_sat32(input logic signed [48:0] v);
        logic signed [31:0] r;
        if (v > S32_MAX) r = 32'sh7FFF_FFFF;
        else if (v < S32_MIN) r = 32'sh8000_0000;
        else r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [47:0] f_sat48(input logic signed [48:0] v);
        logic signed [47:0] r;
        if (v > S48_MAX) r = 48'sh7FFF_FFFF_FFFF;
        else if (v < S48_MIN) r = 48'sh8000_0000_0000;
        else r = v[47:0];
        return r;
    endfunction

    function automatic logic signed [31:0] f_clamp(input logic signed [31:0] v,
                                                   input logic signed [31:0] lo,
                                                   input logic signed [31:0] hi);
        logic signed [31:0] r;
        if (v < lo) r = lo;
        else if (v > hi) r = hi;
        else r = v;
        return r;
    endfunction

endpackage

[hw/rtl/ljr_cfg.sv]
// Configuration register file for the regulator limits, gains and period.
// Depends on ljr_pkg.
module ljr_cfg
    import ljr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    // Write one register per beat; drop writes to unused indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.speed_limit   <= RST_SPEED_LIMIT;
            r_cfg.accel_limit   <= RST_ACCEL_LIMIT;
            r_cfg.jerk_step     <= RST_JERK_STEP;
            r_cfg.sample_period <= RST_SAMPLE_PERIOD;
            r_cfg.speed_gain    <= RST_SPEED_GAIN;
            r_cfg.position_gain <= RST_POSITION_GAIN;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SPEED_LIMIT:   r_cfg.speed_limit   <= i_cfg_wdata;
                CFG_ACCEL_LIMIT:   r_cfg.accel_limit   <= i_cfg_wdata;
                CFG_JERK_STEP:     r_cfg.jerk_step     <= i_cfg_wdata;
                CFG_SAMPLE_PERIOD: r_cfg.sample_period <= i_cfg_wdata;
                CFG_SPEED_GAIN:    r_cfg.speed_gain    <= i_cfg_wdata;
                CFG_POSITION_GAIN: r_cfg.position_gain <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[hw/rtl/ljr_mul.sv]
// Shared signed-by-unsigned multiplier with a registered 64-bit product.
// Depends on ljr_pkg.
module ljr_mul
    import ljr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [31:0] i_a,
    input  logic [CFG_W-1:0]   i_b,
    output logic signed [63:0] o_prod
);

    logic signed [63:0] r_prod;
    logic signed [63:0] n_prod;

    // Gain and period are unsigned: widen with a zero sign bit, then sign-extend
    // both operands so the full 63-bit product is kept
    assign n_prod = 64'(i_a) * 64'($signed({1'b0, i_b}));

    // Hold the product until the next multiply step
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
        end
    end

    assign o_prod = r_prod;

endmodule

[hw/rtl/ljr_ctrl.sv]
// Step sequencer for one regulator tick: drives the shared multiplier
// and the datapath load strobes. Depends on ljr_pkg.
module ljr_ctrl
    import ljr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_out_hold,
    output t_ctrl o_ctrl
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Advance through the steps; hold the last one while the output is full
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:    if (i_in_valid) n_state = ST_MUL_POS;
            ST_MUL_POS: n_state = ST_TERM;
            ST_TERM:    n_state = ST_VREF;
            ST_VREF:    n_state = ST_VERR;
            ST_VERR:    n_state = ST_MUL_SPD;
            ST_MUL_SPD: n_state = ST_ACC;
            ST_ACC:     n_state = ST_DU;
            ST_DU:      n_state = ST_U;
            ST_U:       n_state = ST_MUL_PSP;
            ST_MUL_PSP: n_state = ST_POS;
            ST_POS:     n_state = ST_MUL_UP;
            ST_MUL_UP:  n_state = ST_SPD;
            ST_SPD:     if (!i_out_hold) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // Decode strobes for the current step
    always_comb begin
        o_ctrl = '0;
        o_ctrl.mul_sel = MUL_POS_ERR;
        case (r_state)
            ST_IDLE:    o_ctrl.in_ready = 1'b1;
            ST_MUL_POS: begin
                o_ctrl.mul_en  = 1'b1;
                o_ctrl.mul_sel = MUL_POS_ERR;
            end
            ST_TERM:    o_ctrl.ld_term = 1'b1;
            ST_VREF:    o_ctrl.ld_vref = 1'b1;
            ST_VERR:    o_ctrl.ld_verr = 1'b1;
            ST_MUL_SPD: begin
                o_ctrl.mul_en  = 1'b1;
                o_ctrl.mul_sel = MUL_SPD_ERR;
            end
            ST_ACC:     o_ctrl.ld_acc = 1'b1;
            ST_DU:      o_ctrl.ld_du  = 1'b1;
            ST_U:       o_ctrl.ld_u   = 1'b1;
            ST_MUL_PSP: begin
                o_ctrl.mul_en  = 1'b1;
                o_ctrl.mul_sel = MUL_SPD_PER;
            end
            ST_POS:     o_ctrl.ld_pos = 1'b1;
            ST_MUL_UP:  begin
                o_ctrl.mul_en  = 1'b1;
                o_ctrl.mul_sel = MUL_ACC_PER;
            end
            ST_SPD:     o_ctrl.ld_spd = !i_out_hold;
            default: ;
        endcase
    end

endmodule

[hw/rtl/longitudinal_jerk_limited_regulator_core.sv]
// Longitudinal jerk-limited regulator, top level.
// Depends on ljr_pkg, ljr_cfg, ljr_mul, ljr_ctrl and the assertion header.
//
// One input beat is one control tick. The tick runs as twelve steps on a
// single shared 32x31 multiplier under a sequencer: four multiplies (position
// gain, speed gain, speed times period, acceleration times period), each
// followed by saturate, add and clamp steps. The result beat is registered at
// the last step, which waits while the previous result has not been taken.
// Input is not accepted while a tick is in progress. Model position, speed
// and the previous acceleration reset to zero; configuration writes should
// happen between ticks.
`include "longitudinal_jerk_limited_regulator_core_assert.svh"

module longitudinal_jerk_limited_regulator_core
    import ljr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    // Input stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [63:0]          s_axis_tdata,  // position_error[31:0], speed_setpoint[63:32]
    input  logic [0:0]           s_axis_tuser,  // speed_only[0]
    // Result stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [111:0]         m_axis_tdata   // accel_command[31:0], model_position[79:32],
                                                // model_speed[111:80]
);

    t_cfg  cfg;
    t_ctrl ctl;

    logic signed [31:0] r_perr;
    logic signed [31:0] r_sset;
    logic               r_only;
    logic signed [31:0] r_acc;
    logic signed [31:0] n_acc;
    logic signed [47:0] r_position;
    logic signed [47:0] n_position;
    logic signed [31:0] r_speed;
    logic signed [31:0] n_speed;
    logic signed [31:0] r_prev_accel;
    logic signed [31:0] n_prev_accel;
    logic               r_out_valid;
    logic signed [31:0] r_out_accel;
    logic signed [47:0] r_out_position;
    logic signed [31:0] r_out_speed;

    logic signed [31:0] mul_a;
    logic [CFG_W-1:0]   mul_b;
    logic signed [63:0] prod;
    logic signed [47:0] prod_q;
    logic               out_hold;
    logic               in_beat;

    assign out_hold = r_out_valid && !m_axis_tready;
    assign in_beat  = s_axis_tvalid && ctl.in_ready;

    ljr_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    ljr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_out_hold (out_hold),
        .o_ctrl     (ctl)
    );

    // Select multiplier operands for the current step
    always_comb begin
        case (ctl.mul_sel)
            MUL_POS_ERR: begin
                mul_a = r_perr;
                mul_b = cfg.position_gain;
            end
            MUL_SPD_ERR: begin
                mul_a = r_acc;
                mul_b = cfg.speed_gain;
            end
            MUL_SPD_PER: begin
                mul_a = r_speed;
                mul_b = cfg.sample_period;
            end
            MUL_ACC_PER: begin
                mul_a = r_prev_accel;
                mul_b = cfg.sample_period;
            end
            default: begin
                mul_a = r_perr;
                mul_b = cfg.position_gain;
            end
        endcase
    end

    ljr_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (ctl.mul_en),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    // Arithmetic shift gives the floor of product / 2^16
    assign prod_q = prod[63:16];

    // Working register: term, speed reference, speed error, accel, change
    always_comb begin
        n_acc = r_acc;
        if (ctl.ld_term) begin
            n_acc = r_only ? 32'sd0 : f_sat32(f_ext48(prod_q));
        end else if (ctl.ld_vref) begin
            n_acc = f_clamp(f_sat32(f_ext32(r_acc) + f_ext32(r_sset)),
                            32'sd0, $signed({1'b0, cfg.speed_limit}));
        end else if (ctl.ld_verr) begin
            n_acc = f_sat32(f_ext32(r_acc) - f_ext32(r_speed));
        end else if (ctl.ld_acc) begin
            n_acc = f_sat32(f_ext48(prod_q));
        end else if (ctl.ld_du) begin
            n_acc = f_clamp(f_sat32(f_ext32(r_acc) - f_ext32(r_prev_accel)),
                            -$signed({1'b0, cfg.jerk_step}),
                            $signed({1'b0, cfg.jerk_step}));
        end
    end

    // Limited acceleration and model integration
    assign n_prev_accel = f_clamp(f_sat32(f_ext32(r_prev_accel) + f_ext32(r_acc)),
                                  -$signed({1'b0, cfg.accel_limit}),
                                  $signed({1'b0, cfg.accel_limit}));
    assign n_position   = f_sat48(f_ext48(r_position) + f_ext48(prod_q));
    assign n_speed      = f_sat32(f_ext32(r_speed) + f_ext48(prod_q));

    // Capture the input beat
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_perr <= s_axis_tdata[31:0];
            r_sset <= s_axis_tdata[63:32];
            r_only <= s_axis_tuser[0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    // Model state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position   <= '0;
            r_speed      <= '0;
            r_prev_accel <= '0;
        end else begin
            if (ctl.ld_u) begin
                r_prev_accel <= n_prev_accel;
            end
            if (ctl.ld_pos) begin
                r_position <= n_position;
            end
            if (ctl.ld_spd) begin
                r_speed <= n_speed;
            end
        end
    end

    // Result register: load on the last step, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctl.ld_spd) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.ld_spd) begin
            r_out_accel    <= r_prev_accel;
            r_out_position <= r_position;
            r_out_speed    <= n_speed;
        end
    end

    assign s_axis_tready = ctl.in_ready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_speed, r_out_position, r_out_accel};

    // A taken beat starts a tick, so the next cycle is busy
    `LJR_ASSERT_NEXT(a_busy_after_beat, i_clk, i_rst_n, in_beat, !s_axis_tready)
    // The committed acceleration stays inside the magnitude clamp
    `LJR_ASSERT_NEXT(a_accel_in_limit, i_clk, i_rst_n, ctl.ld_u,
        (r_prev_accel <= $signed({1'b0, cfg.accel_limit})) &&
        (r_prev_accel >= -$signed({1'b0, cfg.accel_limit})))
    // The speed reference is never negative
    `LJR_ASSERT_NEXT(a_vref_nonneg, i_clk, i_rst_n, ctl.ld_vref, !r_acc[31])
    // The last step never overwrites a result that is still waiting
    `LJR_ASSERT_IMPL(a_no_overwrite, i_clk, i_rst_n, ctl.ld_spd,
        !r_out_valid || m_axis_tready)

endmodule

[tb/sv/longitudinal_jerk_limited_regulator_core_tb.sv]
// Self-checking testbench for longitudinal_jerk_limited_regulator_core.
// Depends on ljr_pkg and the regulator RTL; predicts each accel/position/speed beat
// in Q16.16 fixed point and compares it against the result stream.
module longitudinal_jerk_limited_regulator_core_tb;
    import ljr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint Q32_HI = 64'sd2147483647;
    localparam longint Q32_LO = -64'sd2147483648;
    localparam longint Q48_HI = 64'sd140737488355327;
    localparam longint Q48_LO = -64'sd140737488355328;

    // Indexes past the register file; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 3'd7;

    localparam int unsigned LIMIT_CYCLES   = 400000;
    localparam int unsigned HOLDOFF_CYCLES = 250;
    localparam int unsigned TAIL_CYCLES    = 24;

    typedef struct packed {
        logic signed [31:0] position_error;
        logic signed [31:0] speed_setpoint;
        logic               speed_only;
    } t_tick_in;

    typedef struct packed {
        logic signed [31:0] accel_command;
        logic signed [47:0] model_position;
        logic signed [31:0] model_speed;
    } t_tick_cmd;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0]     i_cfg_wdata = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [63:0]          s_axis_tdata = '0;   // position_error[31:0], speed_setpoint[63:32]
    logic [0:0]           s_axis_tuser = '0;   // speed_only[0]
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [111:0]         m_axis_tdata;        // accel_command[31:0], model_position[79:32],
                                               // model_speed[111:80]

    longitudinal_jerk_limited_regulator_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Predictor state and register mirror
    t_cfg   reg_mirror;
    longint mdl_position = 0;
    longint mdl_speed = 0;
    longint last_accel = 0;

    t_tick_in  tick_queue[$];
    t_tick_cmd predicted_cmds[$];

    int unsigned cmd_mismatches = 0;
    int unsigned cmds_seen = 0;
    int unsigned cycle_count = 0;
    bit          in_taken = 1'b0;
    bit          idle_on = 1'b1;

    int unsigned tx_gap = 0;
    int unsigned rx_stall = 0;
    int unsigned holdoff_left = 0;
    int unsigned holdoffs_done = 0;
    int unsigned next_holdoff_at = 60;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic longint sat_q32(longint v);
        if (v > Q32_HI) return Q32_HI;
        if (v < Q32_LO) return Q32_LO;
        return v;
    endfunction

    function automatic longint limit_to(longint v, longint lo, longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // Q16.16 product, floored
    function automatic longint q_mul(longint a, longint g);
        return (a * g) >>> 16;
    endfunction

    // Run one control tick against the mirrored state and registers
    function automatic t_tick_cmd regulate_tick(t_tick_in t);
        longint perr, sset, term, vref, acc, du, u;
        t_tick_cmd r;
        perr = longint'($signed(t.position_error));
        sset = longint'($signed(t.speed_setpoint));
        term = t.speed_only ? 0 : sat_q32(q_mul(perr, longint'(reg_mirror.position_gain)));
        vref = limit_to(sat_q32(term + sset), 0, longint'(reg_mirror.speed_limit));
        acc  = sat_q32(q_mul(sat_q32(vref - mdl_speed), longint'(reg_mirror.speed_gain)));
        du   = limit_to(sat_q32(acc - last_accel), -longint'(reg_mirror.jerk_step),
                        longint'(reg_mirror.jerk_step));
        u    = limit_to(sat_q32(last_accel + du), -longint'(reg_mirror.accel_limit),
                        longint'(reg_mirror.accel_limit));
        last_accel = u;
        // position moves with the speed held before this tick
        mdl_position = limit_to(mdl_position + q_mul(mdl_speed, longint'(reg_mirror.sample_period)),
                                Q48_LO, Q48_HI);
        mdl_speed = sat_q32(mdl_speed + q_mul(u, longint'(reg_mirror.sample_period)));
        r.accel_command  = u[31:0];
        r.model_position = mdl_position[47:0];
        r.model_speed    = mdl_speed[31:0];
        return r;
    endfunction

    function automatic logic [31:0] pick_extreme();
        case ($urandom_range(0, 4))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'h0000_0001;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    function automatic t_tick_in mk_tick(logic [31:0] perr, logic [31:0] sset, logic only);
        t_tick_in t;
        t.position_error = perr;
        t.speed_setpoint = sset;
        t.speed_only     = only;
        return t;
    endfunction

    // Mostly plausible errors and setpoints, some full-range and extreme values
    function automatic t_tick_in rand_tick();
        int span;
        t_tick_in t;
        span = 1 << $urandom_range(12, 24);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
                t.position_error = int'($urandom_range(0, 2 * span)) - span;
                t.speed_setpoint = int'($urandom_range(0, 35 << 16)) - (5 << 16);
            end
            6, 7: begin
                t.position_error = $urandom;
                t.speed_setpoint = $urandom;
            end
            8: begin
                t.position_error = pick_extreme();
                t.speed_setpoint = pick_extreme();
            end
            default: begin
                t.position_error = pick_extreme();
                t.speed_setpoint = int'($urandom_range(0, 35 << 16));
            end
        endcase
        t.speed_only = ($urandom_range(0, 3) == 0);
        return t;
    endfunction

    // Plausible register values; with wild set, some fields span the full range
    function automatic t_cfg draw_cfg(bit wild);
        t_cfg c;
        c.speed_limit   = 31'($urandom_range(0, 40 << 16));
        c.accel_limit   = 31'($urandom_range(0, 20 << 16));
        c.jerk_step     = 31'($urandom_range(0, 2 << 16));
        c.sample_period = 31'($urandom_range(0, 1 << 16));
        c.speed_gain    = 31'($urandom_range(0, 8 << 16));
        c.position_gain = 31'($urandom_range(0, 4 << 16));
        if (wild) begin
            if ($urandom_range(0, 2) == 0) c.speed_limit   = 31'($urandom);
            if ($urandom_range(0, 2) == 0) c.accel_limit   = 31'($urandom);
            if ($urandom_range(0, 2) == 0) c.jerk_step     = 31'($urandom);
            if ($urandom_range(0, 2) == 0) c.sample_period = 31'($urandom);
            if ($urandom_range(0, 2) == 0) c.speed_gain    = 31'($urandom);
            if ($urandom_range(0, 2) == 0) c.position_gain = 31'($urandom);
        end
        return c;
    endfunction

    // One register write; the mirror follows, spare indexes change nothing
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_SPEED_LIMIT:   reg_mirror.speed_limit   = val;
            CFG_ACCEL_LIMIT:   reg_mirror.accel_limit   = val;
            CFG_JERK_STEP:     reg_mirror.jerk_step     = val;
            CFG_SAMPLE_PERIOD: reg_mirror.sample_period = val;
            CFG_SPEED_GAIN:    reg_mirror.speed_gain    = val;
            CFG_POSITION_GAIN: reg_mirror.position_gain = val;
            default: ;
        endcase
    endtask

    task automatic write_all(t_cfg c);
        write_reg(CFG_SPEED_LIMIT, c.speed_limit);
        write_reg(CFG_ACCEL_LIMIT, c.accel_limit);
        write_reg(CFG_JERK_STEP, c.jerk_step);
        write_reg(CFG_SAMPLE_PERIOD, c.sample_period);
        write_reg(CFG_SPEED_GAIN, c.speed_gain);
        write_reg(CFG_POSITION_GAIN, c.position_gain);
        if ($urandom_range(0, 1) == 0)
            write_reg($urandom_range(0, 1) ? CFG_IDX_SPARE_LO : CFG_IDX_SPARE_HI,
                      31'($urandom));
    endtask

    // Wait until every queued tick has gone in and its command has come back
    task automatic drain();
        do @(posedge i_clk);
        while (tick_queue.size() != 0 || s_axis_tvalid || predicted_cmds.size() != 0);
    endtask

    task automatic run_ticks(int n);
        repeat (n) tick_queue.push_back(rand_tick());
        drain();
    endtask

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("status: fail");
            $finish;
        end
    end

    // Monitor: check result beats, then predict for an accepted input beat
    always @(posedge i_clk) begin : monitor
        t_tick_cmd got;
        t_tick_cmd want;
        t_tick_in  seen;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= s_axis_tvalid && s_axis_tready;
            if (m_axis_tvalid && m_axis_tready) begin
                cmds_seen = cmds_seen + 1;
                got.accel_command  = m_axis_tdata[31:0];
                got.model_position = m_axis_tdata[79:32];
                got.model_speed    = m_axis_tdata[111:80];
                if (predicted_cmds.size() == 0) begin
                    cmd_mismatches = cmd_mismatches + 1;
                    if (cmd_mismatches <= 10)
                        $display("unexpected result beat %0d: %h", cmds_seen, got);
                end else begin
                    want = predicted_cmds.pop_front();
                    if (got != want) begin
                        cmd_mismatches = cmd_mismatches + 1;
                        if (cmd_mismatches <= 10)
                            $display({"mismatch beat %0d: accel exp %h got %h, ",
                                      "pos exp %h got %h, speed exp %h got %h"},
                                     cmds_seen, want.accel_command, got.accel_command,
                                     want.model_position, got.model_position,
                                     want.model_speed, got.model_speed);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                seen = mk_tick(s_axis_tdata[31:0], s_axis_tdata[63:32], s_axis_tuser[0]);
                predicted_cmds.push_back(regulate_tick(seen));
            end
        end
    end

    // Driver: hold a beat until taken, then idle in bursts or offer the next tick
    always @(negedge i_clk) begin : driver
        t_tick_in t;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (s_axis_tvalid && !in_taken) begin
            // hold the current beat
        end else if (tx_gap > 0) begin
            tx_gap = tx_gap - 1;
            s_axis_tvalid <= 1'b0;
        end else if (idle_on && $urandom_range(0, 3) == 0) begin
            tx_gap = $urandom_range(1, 6) - 1;
            s_axis_tvalid <= 1'b0;
        end else if (tick_queue.size() != 0) begin
            t = tick_queue.pop_front();
            s_axis_tdata  <= {t.speed_setpoint, t.position_error};
            s_axis_tuser  <= t.speed_only;
            s_axis_tvalid <= 1'b1;
        end else begin
            s_axis_tvalid <= 1'b0;
        end
    end

    // Receiver: long hold-offs at two points so the block backs up, else short stalls
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (holdoff_left > 0) begin
            holdoff_left = holdoff_left - 1;
            m_axis_tready <= 1'b0;
        end else if (holdoffs_done < 2 && cmds_seen >= next_holdoff_at) begin
            holdoff_left    = HOLDOFF_CYCLES - 1;
            holdoffs_done   = holdoffs_done + 1;
            next_holdoff_at = next_holdoff_at + 300;
            m_axis_tready <= 1'b0;
        end else if (rx_stall > 0) begin
            rx_stall = rx_stall - 1;
            m_axis_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            rx_stall = $urandom_range(1, 6) - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Stimulus: phases of ticks, registers rewritten only between phases
    initial begin : stimulus
        t_cfg c;
        reg_mirror = '{speed_limit: RST_SPEED_LIMIT, accel_limit: RST_ACCEL_LIMIT,
                       jerk_step: RST_JERK_STEP, sample_period: RST_SAMPLE_PERIOD,
                       speed_gain: RST_SPEED_GAIN, position_gain: RST_POSITION_GAIN};
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed ticks at reset registers: zero, extremes, speed-only, clamps
        tick_queue.push_back(mk_tick(32'h0000_0000, 32'h0000_0000, 1'b0));
        tick_queue.push_back(mk_tick(32'h7FFF_FFFF, 32'h0000_0000, 1'b0));
        tick_queue.push_back(mk_tick(32'h7FFF_FFFF, 32'h0000_0000, 1'b1));
        tick_queue.push_back(mk_tick(32'h8000_0000, 32'h7FFF_FFFF, 1'b0));
        tick_queue.push_back(mk_tick(32'h0000_0000, 32'h7FFF_FFFF, 1'b0));
        tick_queue.push_back(mk_tick(32'h0000_0000, 32'h8000_0000, 1'b0));
        tick_queue.push_back(mk_tick(32'h8000_0000, 32'h0000_0000, 1'b0));
        tick_queue.push_back(mk_tick(32'h0000_0001, 32'h0000_0001, 1'b0));
        tick_queue.push_back(mk_tick(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0));
        repeat (4) tick_queue.push_back(mk_tick(32'h0000_0000, 32'h000A_0000, 1'b1));
        tick_queue.push_back(mk_tick(32'h0005_0000, 32'h0000_0000, 1'b0));
        tick_queue.push_back(mk_tick(32'hFFFB_0000, 32'h0014_0000, 1'b0));
        tick_queue.push_back(mk_tick(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
        tick_queue.push_back(mk_tick(32'h5555_5555, 32'hAAAA_AAAA, 1'b0));
        tick_queue.push_back(mk_tick(32'hAAAA_AAAA, 32'h5555_5555, 1'b1));
        drain();
        run_ticks(140);

        // Plausible registers plus a dropped spare write
        write_all(draw_cfg(1'b0));
        write_reg(CFG_IDX_SPARE_HI, '1);
        run_ticks(120);

        // Every register at its maximum: saturation throughout, position saturates at its limits
        write_all('{speed_limit: '1, accel_limit: '1, jerk_step: '1, sample_period: '1,
                    speed_gain: '1, position_gain: '1});
        run_ticks(80);

        // Every register at zero, no idling
        idle_on = 1'b0;
        write_all('0);
        run_ticks(40);
        idle_on = 1'b1;

        // Build a large acceleration, then shrink the limits below it
        c = '{speed_limit: '1, accel_limit: '1, jerk_step: '1, sample_period: 31'd1311,
              speed_gain: 31'(8 << 16), position_gain: 31'(1 << 16)};
        write_all(c);
        run_ticks(50);
        write_reg(CFG_ACCEL_LIMIT, 31'(1 << 16));
        write_reg(CFG_JERK_STEP, 31'h1000);
        run_ticks(50);

        // Random register sets, some with idling switched off
        repeat (4) begin
            idle_on = $urandom_range(0, 2) != 0;
            write_all(draw_cfg(1'b1));
            run_ticks(60);
        end

        // Final stretch without idling
        idle_on = 1'b0;
        write_all(draw_cfg(1'b0));
        run_ticks(110);

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (cmd_mismatches == 0 && predicted_cmds.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
